// ===== sv/sbsd_pkg.sv =====
// ----------------------------------------------------------------------------
// sbsd_pkg
// Shared types and constants for the sync byte stuffing deframer.
// ----------------------------------------------------------------------------
package sbsd_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_VALUE    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TICKS = 8'd1;

    // Configuration reset values
    localparam logic [7:0]  SYNC_VALUE_RESET    = 8'd170;
    localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd1000;

    // Input item kinds (carried on s_tuser)
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Receiver phase
    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_CMD  = 2'd1,
        PH_LEN  = 2'd2,
        PH_DATA = 2'd3
    } phase_t;

    // Result kinds (carried on m_tuser)
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_TIMEOUT = 2'd2
    } kind_t;

    // One result item
    typedef struct packed {
        kind_t      kind;
        logic [7:0] frame_cmd;
        logic [7:0] payload_byte;
        logic [7:0] byte_index;
        logic       last;
    } result_t;

endpackage

// ===== sv/sbsd_core.sv =====
// ----------------------------------------------------------------------------
// sbsd_core
// Frame state machine: sync hunt, command, length and unstuffing of payload
// bytes, plus the idle tick counter. Produces at most one result per item.
// ----------------------------------------------------------------------------
module sbsd_core
    import sbsd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        item_valid,
    input  logic        item_action,
    input  logic [7:0]  item_byte,
    input  logic [7:0]  sync_value,
    input  logic [15:0] timeout_ticks,
    output logic        res_valid,
    output result_t     res
);

    phase_t      phase_reg,     phase_next;
    logic [7:0]  cmd_reg,       cmd_next;
    logic [7:0]  remaining_reg, remaining_next;
    logic        skip_reg,      skip_next;
    logic [7:0]  count_reg,     count_next;
    logic [15:0] idle_reg,      idle_next;

    // Shared decode
    logic        is_tick;
    logic        is_byte;
    logic [15:0] idle_inc;
    logic        timed_out;
    logic        is_sync;
    logic [7:0]  rem;
    logic        rem_zero;

    assign is_tick   = item_valid && (item_action == ACT_TICK);
    assign is_byte   = item_valid && (item_action == ACT_BYTE);
    assign idle_inc  = (idle_reg == 16'hFFFF) ? idle_reg : idle_reg + 16'd1;
    assign timed_out = idle_inc >= timeout_ticks;
    assign is_sync   = item_byte == sync_value;
    assign rem       = remaining_reg - 8'd1;
    assign rem_zero  = rem == 8'd0;

    // Next state
    always_comb begin
        phase_next     = phase_reg;
        cmd_next       = cmd_reg;
        remaining_next = remaining_reg;
        skip_next      = skip_reg;
        count_next     = count_reg;
        idle_next      = idle_reg;
        if (is_tick) begin
            if (timed_out) begin
                idle_next   = 16'd0;
                skip_next   = 1'b0;
                phase_next  = PH_HUNT;
            end else begin
                idle_next   = idle_inc;
            end
        end else if (is_byte) begin
            idle_next = 16'd0;
            unique case (phase_reg)
                PH_HUNT: begin
                    if (is_sync) phase_next = PH_CMD;
                end
                PH_CMD: begin
                    if (is_sync) begin
                        phase_next = PH_HUNT;
                    end else begin
                        cmd_next   = item_byte;
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN: begin
                    remaining_next = item_byte;
                    count_next     = 8'd0;
                    skip_next      = 1'b0;
                    phase_next     = (item_byte == 8'd0) ? PH_HUNT : PH_DATA;
                end
                PH_DATA: begin
                    remaining_next = rem;
                    if (skip_reg) begin
                        skip_next = 1'b0;
                    end else begin
                        count_next = count_reg + 8'd1;
                        if (is_sync && !rem_zero) skip_next = 1'b1;
                    end
                    if (rem_zero) phase_next = PH_HUNT;
                end
                default: phase_next = PH_HUNT;
            endcase
        end
    end

    // Result for the current item
    always_comb begin
        res_valid        = 1'b0;
        res.kind         = KIND_PAYLOAD;
        res.frame_cmd    = cmd_reg;
        res.payload_byte = 8'd0;
        res.byte_index   = 8'd0;
        res.last         = 1'b1;
        if (is_tick) begin
            if (timed_out) begin
                res_valid = 1'b1;
                res.kind  = KIND_TIMEOUT;
            end
        end else if (is_byte) begin
            unique case (phase_reg)
                PH_LEN: begin
                    if (item_byte == 8'd0) begin
                        res_valid = 1'b1;
                        res.kind  = KIND_EMPTY;
                    end
                end
                PH_DATA: begin
                    if (!skip_reg) begin
                        res_valid        = 1'b1;
                        res.payload_byte = item_byte;
                        res.byte_index   = count_reg;
                        // an escape with at most one raw byte left closes the frame
                        res.last         = is_sync ? (rem <= 8'd1) : rem_zero;
                    end
                end
                default: res_valid = 1'b0;
            endcase
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HUNT;
            cmd_reg       <= 8'd0;
            remaining_reg <= 8'd0;
            skip_reg      <= 1'b0;
            count_reg     <= 8'd0;
            idle_reg      <= 16'd0;
        end else begin
            phase_reg     <= phase_next;
            cmd_reg       <= cmd_next;
            remaining_reg <= remaining_next;
            skip_reg      <= skip_next;
            count_reg     <= count_next;
            idle_reg      <= idle_next;
        end
    end

    // Checks
    a_timeout_hunts: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && (res.kind == KIND_TIMEOUT) |=> phase_reg == PH_HUNT)
        else $error("timeout result did not return to hunting");

    a_skip_in_data: assert property (@(posedge aclk) disable iff (!aresetn)
        skip_reg |-> phase_reg == PH_DATA)
        else $error("skip flag set outside payload phase");

    a_byte_clears_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        is_byte |=> idle_reg == 16'd0)
        else $error("received byte did not clear idle count");

    a_empty_from_len: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && (res.kind == KIND_EMPTY) |-> phase_reg == PH_LEN)
        else $error("empty frame result outside length phase");

endmodule

// ===== sv/sync_byte_stuffing_deframer.sv =====
// ----------------------------------------------------------------------------
// sync_byte_stuffing_deframer
// Frame receiver for a sync / command / length / stuffed payload byte stream.
// ----------------------------------------------------------------------------
// Each input transfer is either one received byte or one timer tick
// (s_tuser). The block takes one transfer per clock cycle, sustained: the
// frame state is updated in the same cycle and any result is loaded into a
// single output register, which is refilled in the cycle it is taken, so
// s_tready only drops while that register holds a result that m_tready is
// not taking. A result is visible in the cycle after the transfer that caused
// it. Bytes and ticks that cause no result produce no output transfer.
// Configuration writes (sync value, timeout in ticks) are always accepted and
// should be made while the stream is idle.
module sync_byte_stuffing_deframer
    import sbsd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // Input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] rx_byte
    input  logic                   s_tuser,   // [0] action (0 byte, 1 tick)
    // Result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [23:0]            m_tdata,   // [7:0] frame_cmd, [15:8] payload_byte,
                                              // [23:16] byte_index
    output logic [1:0]             m_tuser,   // [1:0] kind
    output logic                   m_tlast,   // last
    // Configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]            cfg_data
);

    logic [7:0]  sync_reg;
    logic [15:0] timeout_reg;
    logic        s_accept;
    logic        res_valid;
    result_t     res;
    logic        m_valid_reg, m_valid_next;
    result_t     m_res_reg;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_reg    <= SYNC_VALUE_RESET;
            timeout_reg <= TIMEOUT_TICKS_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_SYNC_VALUE:    sync_reg    <= cfg_data[7:0];
                REG_TIMEOUT_TICKS: timeout_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input handshake
    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    sbsd_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_valid    (s_accept),
        .item_action   (s_tuser),
        .item_byte     (s_tdata),
        .sync_value    (sync_reg),
        .timeout_ticks (timeout_reg),
        .res_valid     (res_valid),
        .res           (res)
    );

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_accept) begin
            m_valid_next = res_valid;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_res_reg.byte_index, m_res_reg.payload_byte, m_res_reg.frame_cmd};
    assign m_tuser  = m_res_reg.kind;
    assign m_tlast  = m_res_reg.last;

endmodule
